// File: design/fcpm_pkg.sv
// ----------------------------------------------------------------------------
// fcpm_pkg: shared constants for the false-color piecewise-linear map
// Knot table per color channel and the fixed widths of the result fields.
// ----------------------------------------------------------------------------
package fcpm_pkg;

    localparam int LEVEL_BITS_DEF = 12;
    localparam int KNOT_COUNT     = 9;
    localparam int KNOT_IDX_W     = 4;
    localparam int KNOT_W         = 16;
    localparam int COLOR_W        = 8;
    localparam int CHANNEL_COUNT  = 3;

    localparam int CH_RED   = 0;
    localparam int CH_GREEN = 1;
    localparam int CH_BLUE  = 2;

    typedef logic [KNOT_W-1:0] knot_t;
    typedef knot_t             knot_row_t [KNOT_COUNT];
    typedef knot_row_t         knot_tab_t [CHANNEL_COUNT];

    // Knot values are 255 * v with 8 fraction bits, at f = k/8.
    localparam knot_tab_t KNOT_TAB = '{
        '{16'd0, 16'd9792,  16'd19584, 16'd39168, 16'd65280,
          16'd58752, 16'd58752, 16'd58752, 16'd65280},
        '{16'd0, 16'd9792,  16'd9792,  16'd13056, 16'd16320,
          16'd32640, 16'd48960, 16'd58752, 16'd65280},
        '{16'd0, 16'd32640, 16'd48960, 16'd32640, 16'd9792,
          16'd0,     16'd6528,  16'd32640, 16'd65280}
    };

endpackage

// File: design/fcpm_channel.sv
// ----------------------------------------------------------------------------
// fcpm_channel: one color channel of the piecewise-linear map
// Picks the segment knots, interpolates with one multiply, rounds and clamps.
// ----------------------------------------------------------------------------
module fcpm_channel
    import fcpm_pkg::*;
#(
    parameter int LEVEL_BITS = LEVEL_BITS_DEF,
    parameter int CH         = CH_RED
)
(
    input  logic [LEVEL_BITS:0]  level,
    output logic [COLOR_W-1:0]   color
);

    localparam int SEG_BITS = LEVEL_BITS - 3;
    localparam int PROD_W   = KNOT_W + 2 + SEG_BITS;
    localparam int SHIFT    = 8 + SEG_BITS;

    logic                       full;
    logic [2:0]                 seg;
    logic [SEG_BITS-1:0]        off;
    logic [KNOT_IDX_W-1:0]      idx0;
    logic [KNOT_IDX_W-1:0]      idx1;
    knot_t                      k0;
    knot_t                      k1;
    logic signed [KNOT_W:0]     diff;
    logic signed [PROD_W-1:0]   base;
    logic signed [PROD_W-1:0]   prod;
    logic signed [PROD_W-1:0]   half;
    logic signed [PROD_W-1:0]   sum;
    logic [8:0]                 rounded;

    // Any level at or above full scale lands on the last knot with no slope.
    assign full = level[LEVEL_BITS];
    assign seg  = level[LEVEL_BITS-1:SEG_BITS];
    assign off  = full ? '0 : level[SEG_BITS-1:0];
    assign idx0 = full ? KNOT_IDX_W'(KNOT_COUNT - 1) : {1'b0, seg};
    assign idx1 = full ? KNOT_IDX_W'(KNOT_COUNT - 1) : ({1'b0, seg} + 4'd1);

    assign k0   = KNOT_TAB[CH][idx0];
    assign k1   = KNOT_TAB[CH][idx1];
    assign diff = $signed({1'b0, k1}) - $signed({1'b0, k0});

    assign base = $signed({2'b00, k0, {SEG_BITS{1'b0}}});
    assign prod = PROD_W'(diff) * PROD_W'($signed({1'b0, off}));
    assign half = $signed(PROD_W'(1) <<< (SHIFT - 1));
    assign sum  = base + prod + half;

    assign rounded = sum[PROD_W-2:SHIFT];
    assign color   = rounded[8] ? {COLOR_W{1'b1}} : rounded[COLOR_W-1:0];

endmodule

// File: design/false_color_piecewise_map.sv
// ----------------------------------------------------------------------------
// false_color_piecewise_map: intensity to false-color RGB
// Input register, three channel interpolators and a result register.
// ----------------------------------------------------------------------------
//  channel   direction  tdata fields (low bit up)          tuser / tlast
//  s_axis    in         level[LEVEL_BITS:0], zero padded   none
//  m_axis    out        red[7:0], green[7:0], blue[7:0]    none
//
//  One transfer in and one out per cycle when the output is not stalled.
//  Data passes the input register, then the result register, with the
//  channel multiply between them. The stall path runs combinationally from
//  m_axis_tready back to s_axis_tready. Reset clears both valid flags only.
// ----------------------------------------------------------------------------
module false_color_piecewise_map
    import fcpm_pkg::*;
#(
    parameter int LEVEL_BITS = LEVEL_BITS_DEF
)
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    // level in the low LEVEL_BITS+1 bits, zeros above
    input  logic [((LEVEL_BITS + 8) / 8) * 8 - 1:0] s_axis_tdata,
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    // red [7:0], green [15:8], blue [23:16]
    output logic [CHANNEL_COUNT*COLOR_W-1:0]     m_axis_tdata
);

    logic                              in_valid_reg;
    logic [LEVEL_BITS:0]               level_reg;
    logic                              out_valid_reg;
    logic [CHANNEL_COUNT*COLOR_W-1:0]  pixel_reg;
    logic [CHANNEL_COUNT*COLOR_W-1:0]  pixel_next;
    logic                              out_load;
    logic                              in_load;

    assign out_load      = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = !in_valid_reg || out_load;
    assign in_load       = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_axis_tready)
            begin
                in_valid_reg <= s_axis_tvalid;
            end
            if (out_load)
            begin
                out_valid_reg <= in_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_load)
        begin
            level_reg <= s_axis_tdata[LEVEL_BITS:0];
        end
        if (out_load && in_valid_reg)
        begin
            pixel_reg <= pixel_next;
        end
    end

    genvar ch;
    generate
        for (ch = 0; ch < CHANNEL_COUNT; ch++)
        begin : g_channel
            fcpm_channel #(
                .LEVEL_BITS (LEVEL_BITS),
                .CH         (ch)
            ) u_channel (
                .level (level_reg),
                .color (pixel_next[ch*COLOR_W +: COLOR_W])
            );
        end
    endgenerate

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = pixel_reg;

    a_ready_when_empty : assert property (@(posedge clk) disable iff (!rst_n)
        !in_valid_reg |-> s_axis_tready)
        else $error("input refused while the input register is empty");

    a_hold_when_full : assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && out_valid_reg && !m_axis_tready) |-> !s_axis_tready)
        else $error("input taken while both stages are stalled");

    a_accept_fills : assert property (@(posedge clk) disable iff (!rst_n)
        in_load |=> in_valid_reg)
        else $error("accepted transfer did not reach the input register");

    a_full_scale_white : assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && out_load && level_reg[LEVEL_BITS])
        |=> (m_axis_tdata == {(CHANNEL_COUNT*COLOR_W){1'b1}}))
        else $error("full-scale level did not map to white");

endmodule

// File: dv/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: testbench for false_color_piecewise_map
// Streams intensity levels through the mapper under random sender bursts and
// receiver stalls. Each level is predicted to an RGB triple, and every output
// transfer is checked channel by channel against the oldest prediction.
// ----------------------------------------------------------------------------
module tb;

    import fcpm_pkg::*;

    localparam int LEVEL_BITS = 12;
    localparam int LEVEL_W    = LEVEL_BITS + 1;
    localparam int TDATA_W    = ((LEVEL_BITS + 8) / 8) * 8;
    localparam int RGB_W      = CHANNEL_COUNT * COLOR_W;
    localparam int SEG_BITS   = LEVEL_BITS - 3;
    localparam int SEG_SIZE   = 1 << SEG_BITS;
    localparam int FULL_SCALE = 1 << LEVEL_BITS;
    localparam int LEVEL_MAX  = (1 << LEVEL_W) - 1;
    localparam int ROUND_SH   = 8 + SEG_BITS;
    localparam int IDLE_LIMIT = 2000;
    localparam int RANDOM_CNT = 1530;

    // Knot rows, knot 0 in the lowest 16 bits.
    localparam logic [9*16-1:0] RED_KNOTS = {
        16'd65280, 16'd58752, 16'd58752, 16'd58752, 16'd65280,
        16'd39168, 16'd19584, 16'd9792,  16'd0};
    localparam logic [9*16-1:0] GREEN_KNOTS = {
        16'd65280, 16'd58752, 16'd48960, 16'd32640, 16'd16320,
        16'd13056, 16'd9792,  16'd9792,  16'd0};
    localparam logic [9*16-1:0] BLUE_KNOTS = {
        16'd65280, 16'd32640, 16'd6528,  16'd0,     16'd9792,
        16'd32640, 16'd48960, 16'd32640, 16'd0};

    typedef struct {
        logic [LEVEL_W-1:0] level;
        bit                 drain_first;
    } level_item_t;

    logic               clk;
    logic               rst_n = 1'b0;
    logic               s_axis_tvalid = 1'b0;
    logic               s_axis_tready;
    logic [TDATA_W-1:0] s_axis_tdata = '0;
    logic               m_axis_tvalid;
    logic               m_axis_tready = 1'b0;
    logic [RGB_W-1:0]   m_axis_tdata;

    level_item_t        pending_levels [$];
    logic [RGB_W-1:0]   rgb_expected [$];

    int total_items     = 0;
    int items_accepted  = 0;
    int mismatch_count  = 0;
    int idle_cycles     = 0;
    int burst_left      = 0;
    int gap_left        = 0;
    int ready_mode      = 0;
    int ready_mode_left = 0;
    int ready_phase     = 0;

    false_color_piecewise_map #(
        .LEVEL_BITS (LEVEL_BITS)
    ) i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    function automatic logic [COLOR_W-1:0] interpolate_channel(
        input logic [9*16-1:0]  knots,
        input logic [LEVEL_W-1:0] level
    );
        int unsigned      lvl;
        int unsigned      seg;
        int unsigned      off;
        longint unsigned  num;
        longint unsigned  res;
        lvl = (level > FULL_SCALE) ? FULL_SCALE : level;
        seg = lvl >> SEG_BITS;
        off = lvl & (SEG_SIZE - 1);
        if (seg >= KNOT_COUNT - 1)
        begin
            num = longint'(knots[(KNOT_COUNT-1)*16 +: 16]) << SEG_BITS;
        end
        else
        begin
            num = longint'(knots[seg*16 +: 16]) * (SEG_SIZE - off)
                + longint'(knots[(seg+1)*16 +: 16]) * off;
        end
        res = (num + (64'd1 << (ROUND_SH - 1))) >> ROUND_SH;
        if (res > 255)
        begin
            res = 255;
        end
        return res[COLOR_W-1:0];
    endfunction

    // Packed the way the output bus carries it: red lowest, blue highest.
    function automatic logic [RGB_W-1:0] mapped_color(input logic [LEVEL_W-1:0] level);
        return {interpolate_channel(BLUE_KNOTS, level),
                interpolate_channel(GREEN_KNOTS, level),
                interpolate_channel(RED_KNOTS, level)};
    endfunction

    function automatic string channel_name(input int ch);
        case (ch)
            CH_RED:   return "red";
            CH_GREEN: return "green";
            default:  return "blue";
        endcase
    endfunction

    task automatic queue_level(input int level, input bit drain_first);
        level_item_t item;
        item.level       = level[LEVEL_W-1:0];
        item.drain_first = drain_first;
        pending_levels.push_back(item);
    endtask

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Stimulus and end of run.
    initial
    begin
        int pick;
        int level;
        int directed [$];
        directed = '{0, 1, 255, 256, 511, 512, 513, 1023, 1024, 1536, 2048,
                     2560, 3072, 3584, 4095, 4096, 4097, 4608, 5000, 6143,
                     8190, LEVEL_MAX};
        foreach (directed[i])
        begin
            queue_level(directed[i], 1'b0);
        end
        for (int i = 0; i < RANDOM_CNT; i++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 10)
            begin
                level = $urandom_range(FULL_SCALE + 1, LEVEL_MAX);
            end
            else if (pick < 20)
            begin
                // Close to a knot, where segment selection changes.
                level = $urandom_range(0, KNOT_COUNT - 1) * SEG_SIZE
                      + $urandom_range(0, 6) - 3;
                if (level < 0)
                begin
                    level = 0;
                end
            end
            else
            begin
                level = $urandom_range(0, FULL_SCALE);
            end
            queue_level(level, (i % 500) == 0);
        end
        total_items = pending_levels.size();

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        while (items_accepted < total_items || rgb_expected.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (10) @(posedge clk);
        if (mismatch_count == 0)
        begin
            $display("TB_OK");
        end
        else
        begin
            $display("TB_ERROR");
        end
        $finish;
    end

    // Driver: bursts of transfers separated by random gaps.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                rgb_expected.push_back(mapped_color(s_axis_tdata[LEVEL_W-1:0]));
                items_accepted++;
            end
            if (!s_axis_tvalid || s_axis_tready)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    s_axis_tvalid <= 1'b0;
                end
                else if (pending_levels.size() != 0 &&
                         !(pending_levels[0].drain_first && rgb_expected.size() != 0))
                begin
                    s_axis_tdata  <= TDATA_W'(pending_levels[0].level);
                    s_axis_tvalid <= 1'b1;
                    void'(pending_levels.pop_front());
                    if (burst_left > 0)
                    begin
                        burst_left--;
                    end
                    else
                    begin
                        burst_left = $urandom_range(1, 40);
                        gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
                    end
                end
                else
                begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // Monitor: checks each output transfer and drives the stall pattern.
    always @(posedge clk)
    begin
        logic [RGB_W-1:0] expected_rgb;
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (rgb_expected.size() == 0)
                begin
                    $display("%0t: unexpected transfer, expected none, actual %h",
                             $time, m_axis_tdata);
                    mismatch_count++;
                end
                else
                begin
                    expected_rgb = rgb_expected.pop_front();
                    for (int ch = 0; ch < CHANNEL_COUNT; ch++)
                    begin
                        if (m_axis_tdata[ch*COLOR_W +: COLOR_W] !==
                            expected_rgb[ch*COLOR_W +: COLOR_W])
                        begin
                            $display("%0t: %s mismatch, expected %0d, actual %0d",
                                     $time, channel_name(ch),
                                     expected_rgb[ch*COLOR_W +: COLOR_W],
                                     m_axis_tdata[ch*COLOR_W +: COLOR_W]);
                            mismatch_count++;
                        end
                    end
                end
            end

            if (ready_mode_left == 0)
            begin
                ready_mode      = $urandom_range(0, 3);
                ready_mode_left = $urandom_range(64, 256);
            end
            ready_mode_left--;
            ready_phase++;
            case (ready_mode)
                0:       m_axis_tready <= 1'b1;
                1:       m_axis_tready <= 1'($urandom_range(0, 1));
                2:       m_axis_tready <= (ready_phase % 4) == 0;
                default: m_axis_tready <= $urandom_range(0, 9) != 0;
            endcase
        end
    end

    // Watchdog on cycles without any transfer.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            begin
                idle_cycles <= 0;
            end
            else if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("TB_ERROR");
                $finish;
            end
            else
            begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

endmodule

// File: filelist.f
design/fcpm_pkg.sv
design/fcpm_channel.sv
design/false_color_piecewise_map.sv
dv/tb.sv
